@@ hw/rtl/spjt_pkg.sv @@
// ----------------------------------------------------------------------------
// Step pulse job tracker package
// Shared widths, event codes and constants for the job tracker and its
// progress divider.
// ----------------------------------------------------------------------------
package spjt_pkg;

  localparam int COUNT_W = 32;
  localparam int MODE_W  = 3;
  localparam int PCT_W   = 7;

  // Quotient bits produced by the serial divider; two more than the percent
  // width so that out-of-range quotients can be seen and capped.
  localparam int QUO_W   = 9;
  // Working width of the divider: holds count * 100 and target << (QUO_W-1).
  localparam int DIV_W   = COUNT_W + QUO_W;
  localparam int STEP_W  = 4;

  localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_PULSE      = 3'd0,
    MODE_START      = 3'd1,
    MODE_CONTINUOUS = 3'd2,
    MODE_PAUSE      = 3'd3,
    MODE_RESUME     = 3'd4,
    MODE_ABORT      = 3'd5
  } mode_t;

endpackage

@@ hw/rtl/spjt_if.sv @@
// ----------------------------------------------------------------------------
// Step pulse job tracker channels
// Valid/ready channels for events going in and status words coming out.
// ----------------------------------------------------------------------------
interface spjt_in_if;
  logic                         valid;
  logic                         ready;
  logic [spjt_pkg::MODE_W-1:0]  mode;
  logic [spjt_pkg::COUNT_W-1:0] pulse_target;
  logic                         dir_request;

  modport source (output valid, output mode, output pulse_target,
                  output dir_request, input ready);
  modport sink   (input valid, input mode, input pulse_target,
                  input dir_request, output ready);
endinterface

interface spjt_out_if;
  logic                         valid;
  logic                         ready;
  logic [spjt_pkg::COUNT_W-1:0] emitted_count;
  logic [spjt_pkg::PCT_W-1:0]   progress_percent;
  logic                         moving;
  logic                         paused_flag;
  logic                         done_res;
  logic                         continuous_flag;
  logic                         step_direction;

  modport source (output valid, output emitted_count, output progress_percent,
                  output moving, output paused_flag, output done_res,
                  output continuous_flag, output step_direction, input ready);
  modport sink   (input valid, input emitted_count, input progress_percent,
                  input moving, input paused_flag, input done_res,
                  input continuous_flag, input step_direction, output ready);
endinterface

@@ hw/rtl/step_pulse_job_tracker.sv @@
// ----------------------------------------------------------------------------
// Step pulse job tracker
// Follows one stepper axis job and reports count, progress and flags for
// every event.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Word
//   in_ch     input      valid / ready      mode, pulse_target, dir_request
//   out_ch    output     valid / ready      count, percent and five flags
//
// Each event passes from acceptance to its status word in these steps: the
// divider is loaded, nine quotient steps run in the subtract/compare unit, the
// sequencer sees the divider finish and the word is registered. The input is
// ready again the cycle after the word is registered.
// Reset (rst_n low, synchronous) clears the job state and empties the output.
// A status word waiting on out_ch does not block the next event; a finished
// result waits only if the previous word has still not been taken.
// ----------------------------------------------------------------------------
module step_pulse_job_tracker (
  input logic        clk,
  input logic        rst_n,
  spjt_in_if.sink    in_ch,
  spjt_out_if.source out_ch
);
  import spjt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_FIN
  } fsm_t;

  fsm_t               fsm_r;

  // Job state as the event sequence leaves it.
  logic [COUNT_W-1:0] target_count_r, target_count_nxt;
  logic [COUNT_W-1:0] pulse_count_r,  pulse_count_nxt;
  logic               dir_bit_r,      dir_bit_nxt;
  logic               run_bit_r,      run_bit_nxt;
  logic               pause_bit_r,    pause_bit_nxt;
  logic               endless_bit_r,  endless_bit_nxt;
  logic               finished_bit_r, finished_bit_nxt;

  // Output register.
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic               out_moving_r;
  logic               out_paused_r;
  logic               out_done_r;
  logic               out_cont_r;
  logic               out_dir_r;

  logic               in_fire;
  logic               out_free;
  logic               load_out;
  logic               div_start;
  logic               div_done;
  logic [PCT_W-1:0]   div_pct;
  logic [COUNT_W-1:0] pulse_inc;

  assign in_ch.ready = (fsm_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (fsm_r == ST_FIN) && out_free;
  assign div_start   = (fsm_r == ST_LAUNCH);
  assign pulse_inc   = pulse_count_r + 1'b1;

  // Next job state for the event on the input channel.
  always_comb begin
    target_count_nxt = target_count_r;
    pulse_count_nxt  = pulse_count_r;
    dir_bit_nxt      = dir_bit_r;
    run_bit_nxt      = run_bit_r;
    pause_bit_nxt    = pause_bit_r;
    endless_bit_nxt  = endless_bit_r;
    finished_bit_nxt = finished_bit_r;
    case (mode_t'(in_ch.mode))
      MODE_PULSE: begin
        // A counted job clamps at its target and completes there; a
        // continuous job simply wraps.
        if (run_bit_r && !pause_bit_r) begin
          pulse_count_nxt = pulse_inc;
          if (!endless_bit_r && (pulse_inc >= target_count_r)) begin
            pulse_count_nxt  = target_count_r;
            run_bit_nxt      = 1'b0;
            finished_bit_nxt = 1'b1;
          end
        end
      end
      MODE_START: begin
        target_count_nxt = in_ch.pulse_target;
        pulse_count_nxt  = '0;
        dir_bit_nxt      = in_ch.dir_request;
        pause_bit_nxt    = 1'b0;
        endless_bit_nxt  = 1'b0;
        // A job of zero pulses is complete the moment it starts.
        finished_bit_nxt = (in_ch.pulse_target == '0);
        run_bit_nxt      = (in_ch.pulse_target != '0);
      end
      MODE_CONTINUOUS: begin
        target_count_nxt = '0;
        pulse_count_nxt  = '0;
        dir_bit_nxt      = in_ch.dir_request;
        run_bit_nxt      = 1'b1;
        pause_bit_nxt    = 1'b0;
        endless_bit_nxt  = 1'b1;
        finished_bit_nxt = 1'b0;
      end
      MODE_PAUSE: begin
        if (run_bit_r) begin
          pause_bit_nxt = 1'b1;
        end
      end
      MODE_RESUME: begin
        if (run_bit_r) begin
          pause_bit_nxt = 1'b0;
        end
      end
      MODE_ABORT: begin
        // Counts and direction survive an abort.
        run_bit_nxt      = 1'b0;
        pause_bit_nxt    = 1'b0;
        endless_bit_nxt  = 1'b0;
        finished_bit_nxt = 1'b0;
      end
      default: begin
        // Unused codes leave the job untouched and still report status.
      end
    endcase
  end

  // The divider sees the job state after the event has been applied.
  spjt_pct_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .count   (pulse_count_r),
    .target  (target_count_r),
    .done    (div_done),
    .percent (div_pct)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r          <= ST_IDLE;
      target_count_r <= '0;
      pulse_count_r  <= '0;
      dir_bit_r      <= 1'b0;
      run_bit_r      <= 1'b0;
      pause_bit_r    <= 1'b0;
      endless_bit_r  <= 1'b0;
      finished_bit_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        target_count_r <= target_count_nxt;
        pulse_count_r  <= pulse_count_nxt;
        dir_bit_r      <= dir_bit_nxt;
        run_bit_r      <= run_bit_nxt;
        pause_bit_r    <= pause_bit_nxt;
        endless_bit_r  <= endless_bit_nxt;
        finished_bit_r <= finished_bit_nxt;
      end

      case (fsm_r)
        ST_IDLE: begin
          if (in_fire) begin
            fsm_r <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: fsm_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            fsm_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            fsm_r <= ST_IDLE;
          end
        end
        default: fsm_r <= ST_IDLE;
      endcase

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Status word payload; loaded from the settled job state and quotient.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count_r  <= pulse_count_r;
      out_pct_r    <= (endless_bit_r || (target_count_r == '0)) ? '0 : div_pct;
      out_moving_r <= run_bit_r && !pause_bit_r;
      out_paused_r <= pause_bit_r;
      out_done_r   <= finished_bit_r;
      out_cont_r   <= endless_bit_r;
      out_dir_r    <= dir_bit_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.emitted_count    = out_count_r;
  assign out_ch.progress_percent = out_pct_r;
  assign out_ch.moving           = out_moving_r;
  assign out_ch.paused_flag      = out_paused_r;
  assign out_ch.done_res         = out_done_r;
  assign out_ch.continuous_flag  = out_cont_r;
  assign out_ch.step_direction   = out_dir_r;

  // The divider only finishes while the sequencer is waiting on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (fsm_r == ST_WAIT))
    else $error("divider finished outside the wait state");

  // Progress never exceeds a full job.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r <= FULL_PERCENT))
    else $error("progress percent above full scale");

  // A completed job is never reported as still moving.
  a_done_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_moving_r))
    else $error("job reported both done and moving");

endmodule

@@ hw/rtl/spjt_pct_div.sv @@
// ----------------------------------------------------------------------------
// Progress percent divider
// Restoring divider, one quotient bit per cycle, for count * 100 / target.
// ----------------------------------------------------------------------------
module spjt_pct_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [spjt_pkg::COUNT_W-1:0] count,
  input  logic [spjt_pkg::COUNT_W-1:0] target,
  output logic                         done,
  output logic [spjt_pkg::PCT_W-1:0]   percent
);
  import spjt_pkg::*;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  div_state_t        state_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsh_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              done_r;

  logic [DIV_W-1:0]  count_ext;
  logic [DIV_W-1:0]  scaled;
  logic [DIV_W:0]    diff;

  // Times 100 as 64 + 32 + 4.
  assign count_ext = {{(DIV_W-COUNT_W){1'b0}}, count};
  assign scaled    = (count_ext << 6) + (count_ext << 5) + (count_ext << 2);
  assign diff      = {1'b0, rem_r} - {1'b0, dsh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        DIV_IDLE: begin
          if (start) begin
            rem_r   <= scaled;
            dsh_r   <= {1'b0, target, {(QUO_W-1){1'b0}}};
            quo_r   <= '0;
            step_r  <= STEP_W'(QUO_W-1);
            state_r <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          // A clear borrow means the shifted divisor fits.
          quo_r <= {quo_r[QUO_W-2:0], ~diff[DIV_W]};
          if (!diff[DIV_W]) begin
            rem_r <= diff[DIV_W-1:0];
          end
          dsh_r <= dsh_r >> 1;
          if (step_r == '0) begin
            state_r <= DIV_IDLE;
            done_r  <= 1'b1;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: state_r <= DIV_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign percent = (quo_r > QUO_W'(FULL_PERCENT)) ? FULL_PERCENT : quo_r[PCT_W-1:0];

endmodule
